FILE: hw/rtl/modem_response_classifier_macros.svh
// Assertion macros for the modem response classifier RTL.
// The assertion forms are included in simulation and left empty for synthesis.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MODEM_RESPONSE_CLASSIFIER_MACROS_SVH
`define MODEM_RESPONSE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

`define MRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("modem_response_classifier: assertion failed");

`define MRC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("modem_response_classifier: forbidden condition seen");

`else

`define MRC_ASSERT(lbl, prop)

`define MRC_ASSERT_NEVER(lbl, cond)

`endif

`endif

FILE: hw/rtl/mrc_pkg.sv
// Package for the modem response classifier: verdict codes, parser phases
// and the result keyword table. It has no dependencies.
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int unsigned NumKw    = 9;
  localparam int unsigned KwSlots  = 16;
  localparam int unsigned KwPosW   = 4;

  typedef enum logic [3:0] {
    VNone      = 4'd0,
    VOk        = 4'd1,
    VError     = 4'd2,
    VConnect   = 4'd3,
    VRing      = 4'd4,
    VBusy      = 4'd5,
    VNoAnswer  = 4'd6,
    VNoCarrier = 4'd7,
    VNoDialTone = 4'd8,
    VUnknown   = 4'd9
  } verdict_e;

  typedef enum logic [5:0] {
    PhFirst  = 6'b000001,
    PhSecond = 6'b000010,
    PhEcho   = 6'b000100,
    PhGap    = 6'b001000,
    PhMatch  = 6'b010000,
    PhDone   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic             hit;
    verdict_e         hit_verdict;
    logic [NumKw-1:0] next_alive;
  } match_res_t;

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;

  localparam logic [7:0] KwText [NumKw][KwSlots] = '{
    '{"O", "K", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"E", "R", "R", "O", "R", 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"C", "O", "N", "N", "E", "C", "T", 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"R", "I", "N", "G", 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"B", "U", "S", "Y", 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"N", "O", " ", "A", "N", "S", "W", "E",
      "R", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"N", "O", " ", "C", "A", "R", "R", "I",
      "E", "R", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"N", "O", " ", "D", "I", "A", "L", "T",
      "O", "N", "E", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"N", "O", " ", "D", "I", "A", "L", " ",
      "T", "O", "N", "E", 8'd0, 8'd0, 8'd0, 8'd0}
  };

  localparam logic [KwPosW-1:0] KwLen [NumKw] = '{
    4'd2, 4'd5, 4'd7, 4'd4, 4'd4, 4'd9, 4'd10, 4'd11, 4'd12
  };

  localparam verdict_e KwVerdict [NumKw] = '{
    VOk, VError, VConnect, VRing, VBusy, VNoAnswer, VNoCarrier,
    VNoDialTone, VNoDialTone
  };

endpackage

FILE: hw/rtl/mrc_match.sv
// Keyword matcher: compares one folded byte at the current position against
// all keywords still alive. Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_match (
  input  logic [7:0]                      ch_i,
  input  logic [mrc_pkg::KwPosW-1:0]      pos_i,
  input  logic [mrc_pkg::NumKw-1:0]       alive_i,
  output mrc_pkg::match_res_t             res_o
);

  logic [mrc_pkg::NumKw-1:0] cmp;
  logic [mrc_pkg::NumKw-1:0] done;

  always_comb begin
    for (int k = 0; k < mrc_pkg::NumKw; k++) begin
      cmp[k]  = alive_i[k] && (pos_i < mrc_pkg::KwLen[k]) &&
                (mrc_pkg::KwText[k][pos_i] == ch_i);
      done[k] = cmp[k] &&
                (({1'b0, pos_i} + 5'd1) == {1'b0, mrc_pkg::KwLen[k]});
    end
  end

  always_comb begin
    res_o.hit         = 1'b0;
    res_o.hit_verdict = mrc_pkg::VNone;
    res_o.next_alive  = cmp;
    for (int k = mrc_pkg::NumKw - 1; k >= 0; k--) begin
      if (done[k]) begin
        res_o.hit         = 1'b1;
        res_o.hit_verdict = mrc_pkg::KwVerdict[k];
      end
    end
  end

endmodule

FILE: hw/rtl/modem_response_classifier.sv
// Top level of the modem response classifier: input stage, parser state and
// result register. Depends on mrc_pkg, mrc_match and the assertion macro header.
//
// Takes one reply byte per item and gives one verdict on each item marked last,
// after which the parser returns to its reset state. An accepted byte is held in
// the input register, where the parser state and the keyword matcher process it;
// for a last byte the verdict is then written to the result register. One byte is
// taken every cycle; the input only waits when a last byte is ready while the result
// register still holds an untaken verdict.
`timescale 1ns / 1ps

`include "modem_response_classifier_macros.svh"

module modem_response_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] verdict_o
);

  logic                              s1_valid_q;
  logic [7:0]                        ch_q;
  logic                              last_q;
  logic                              s1_take;

  mrc_pkg::phase_e                   phase_q, phase_d;
  logic [mrc_pkg::KwPosW-1:0]        pos_q, pos_d;
  logic [mrc_pkg::NumKw-1:0]         alive_q, alive_d;
  mrc_pkg::verdict_e                 decided_q, decided_d;

  logic                              out_valid_q;
  mrc_pkg::verdict_e                 verdict_q, verdict_d;

  logic [7:0]                        ch_up;
  logic                              crlf;
  logic                              is_nul;
  mrc_pkg::match_res_t               mres;

  assign s1_take    = s1_valid_q && !(last_q && out_valid_q && !out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  assign ch_up  = ((ch_q >= "a") && (ch_q <= "z")) ? (ch_q - 8'd32) : ch_q;
  assign crlf   = (ch_q == mrc_pkg::ChCr) || (ch_q == mrc_pkg::ChLf);
  assign is_nul = (ch_q == mrc_pkg::ChNul);

  mrc_match u_match (
    .ch_i    (ch_up),
    .pos_i   (pos_q),
    .alive_i (alive_q),
    .res_o   (mres)
  );

  always_comb begin
    logic gap_path;
    logic match_path;
    gap_path   = 1'b0;
    match_path = 1'b0;
    phase_d    = phase_q;
    pos_d      = pos_q;
    alive_d    = alive_q;
    decided_d  = decided_q;
    verdict_d  = mrc_pkg::VNone;

    unique case (phase_q)
      mrc_pkg::PhFirst: begin
        if (ch_up == "A") begin
          phase_d = mrc_pkg::PhSecond;
        end else begin
          phase_d  = mrc_pkg::PhGap;
          gap_path = 1'b1;
        end
      end
      mrc_pkg::PhSecond: begin
        if (ch_up == "T") begin
          phase_d = mrc_pkg::PhEcho;
        end else begin
          phase_d   = mrc_pkg::PhDone;
          decided_d = mrc_pkg::VUnknown;
        end
      end
      mrc_pkg::PhEcho: begin
        if (is_nul) begin
          phase_d   = mrc_pkg::PhDone;
          decided_d = mrc_pkg::VNone;
        end else if (crlf) begin
          phase_d = mrc_pkg::PhGap;
        end
      end
      mrc_pkg::PhGap: begin
        gap_path = 1'b1;
      end
      mrc_pkg::PhMatch: begin
        if (is_nul) begin
          phase_d   = mrc_pkg::PhDone;
          decided_d = mrc_pkg::VUnknown;
        end else begin
          match_path = 1'b1;
        end
      end
      mrc_pkg::PhDone: begin
      end
      default: begin
      end
    endcase

    if (gap_path) begin
      if (is_nul) begin
        phase_d   = mrc_pkg::PhDone;
        decided_d = mrc_pkg::VNone;
      end else if (!crlf) begin
        match_path = 1'b1;
      end
    end

    if (match_path) begin
      if (mres.hit) begin
        phase_d   = mrc_pkg::PhDone;
        decided_d = mres.hit_verdict;
      end else if (mres.next_alive == '0) begin
        phase_d   = mrc_pkg::PhDone;
        decided_d = mrc_pkg::VUnknown;
      end else begin
        phase_d = mrc_pkg::PhMatch;
        alive_d = mres.next_alive;
        pos_d   = pos_q + mrc_pkg::KwPosW'(1);
      end
    end

    if (phase_d == mrc_pkg::PhDone) begin
      verdict_d = decided_d;
    end else if ((phase_d == mrc_pkg::PhMatch) || (phase_d == mrc_pkg::PhSecond)) begin
      verdict_d = mrc_pkg::VUnknown;
    end

    if (last_q) begin
      phase_d   = mrc_pkg::PhFirst;
      pos_d     = '0;
      alive_d   = '1;
      decided_d = mrc_pkg::VNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mrc_pkg::PhFirst;
      pos_q     <= '0;
      alive_q   <= '1;
      decided_q <= mrc_pkg::VNone;
    end else if (s1_take) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      alive_q   <= alive_d;
      decided_q <= decided_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_take && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && last_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  `MRC_ASSERT(a_last_gives_result, (s1_take && last_q) |=> out_valid_q)
  `MRC_ASSERT(a_last_clears_state, (s1_take && last_q) |=>
      ((phase_q == mrc_pkg::PhFirst) && (pos_q == '0) && (alive_q == '1)))
  `MRC_ASSERT(a_verdict_in_range, out_valid_q |-> (verdict_q <= mrc_pkg::VUnknown))
  `MRC_ASSERT_NEVER(a_alive_never_empty, alive_q == '0)

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for modem_response_classifier: directed replies from a table,
// then random replies, with the verdicts checked against the table or an in-file model of the parser.
// Depends on mrc_pkg for the verdict codes, the parser phases and ChNul, ChCr and ChLf.
`timescale 1ns / 1ps

module testbench;

  localparam int IdleLimit   = 2000;
  localparam int RandomBytes = 800;

  typedef struct {
    string             txt;
    bit                nul_tail;
    bit                typed;
    mrc_pkg::verdict_e want;
  } reply_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] ch_i        = 8'h00;
  logic       last_i      = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] verdict_o;

  string    kw_str  [9] = '{"OK", "ERROR", "CONNECT", "RING", "BUSY", "NO ANSWER",
                            "NO CARRIER", "NO DIALTONE", "NO DIAL TONE"};
  mrc_pkg::verdict_e kw_code [9] = '{mrc_pkg::VOk, mrc_pkg::VError, mrc_pkg::VConnect,
                                     mrc_pkg::VRing, mrc_pkg::VBusy, mrc_pkg::VNoAnswer,
                                     mrc_pkg::VNoCarrier, mrc_pkg::VNoDialTone,
                                     mrc_pkg::VNoDialTone};

  reply_row_t directed_rows [20] = '{
    '{"\r\nOK\r\n", 1'b0, 1'b1, mrc_pkg::VOk},
    '{"at\r\nERROR", 1'b0, 1'b1, mrc_pkg::VError},
    '{"AT+X\rconnect", 1'b0, 1'b1, mrc_pkg::VConnect},
    '{"ring", 1'b0, 1'b1, mrc_pkg::VRing},
    '{"BuSy", 1'b0, 1'b1, mrc_pkg::VBusy},
    '{"NO ANSWER", 1'b0, 1'b1, mrc_pkg::VNoAnswer},
    '{"no carrier", 1'b0, 1'b1, mrc_pkg::VNoCarrier},
    '{"No DialTone", 1'b0, 1'b1, mrc_pkg::VNoDialTone},
    '{"NO DIAL TONE", 1'b0, 1'b1, mrc_pkg::VNoDialTone},
    '{"A", 1'b0, 1'b1, mrc_pkg::VUnknown},
    '{"Ax", 1'b0, 1'b1, mrc_pkg::VUnknown},
    '{"NO CARR", 1'b0, 1'b1, mrc_pkg::VUnknown},
    '{"ATZ\r\n", 1'b0, 1'b1, mrc_pkg::VNone},
    '{"\n\r", 1'b0, 1'b1, mrc_pkg::VNone},
    '{"", 1'b1, 1'b1, mrc_pkg::VNone},
    '{"ATH", 1'b1, 1'b1, mrc_pkg::VNone},
    '{"OKAY", 1'b0, 1'b0, mrc_pkg::VNone},
    '{"NO", 1'b1, 1'b1, mrc_pkg::VUnknown},
    '{"\377", 1'b0, 1'b1, mrc_pkg::VUnknown},
    '{"`K@T", 1'b0, 1'b0, mrc_pkg::VNone}
  };

  // Parser state of the model.
  mrc_pkg::phase_e   parse_phase   = mrc_pkg::PhFirst;
  logic [3:0]        kw_pos        = '0;
  logic [8:0]        kw_alive      = '1;
  mrc_pkg::verdict_e fixed_verdict = mrc_pkg::VNone;

  mrc_pkg::verdict_e verdicts_due [$];
  mrc_pkg::verdict_e got_expect;
  bit       idle_on = 1'b0;
  int       errors = 0;
  int       bytes_sent = 0;
  int       replies_sent = 0;
  int       verdicts_checked = 0;
  int       stall_left = 0;
  int       idle_cycles = 0;
  int       seen_verdict [10];

  modem_response_classifier i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .verdict_o  (verdict_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] mixcase(input logic [7:0] c);
    if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic void fix_verdict(input mrc_pkg::verdict_e v);
    fixed_verdict = v;
    parse_phase = mrc_pkg::PhDone;
  endfunction

  function automatic void clear_parser();
    parse_phase = mrc_pkg::PhFirst;
    kw_pos = '0;
    kw_alive = '1;
    fixed_verdict = mrc_pkg::VNone;
  endfunction

  function automatic void match_char(input logic [7:0] c_in);
    logic [7:0] c;
    logic [8:0] still;
    c = c_in;
    still = '0;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    for (int k = 0; k < 9; k++) begin
      if (kw_alive[k] && int'(kw_pos) < kw_str[k].len() && kw_str[k][kw_pos] == c) begin
        if (int'(kw_pos) + 1 == kw_str[k].len()) begin
          fix_verdict(kw_code[k]);
          return;
        end
        still[k] = 1'b1;
      end
    end
    if (still == '0) begin
      fix_verdict(mrc_pkg::VUnknown);
    end else begin
      kw_alive = still;
      kw_pos = kw_pos + 4'd1;
    end
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    bit crlf;
    bit to_gap;
    crlf = (c == mrc_pkg::ChCr || c == mrc_pkg::ChLf);
    to_gap = 1'b0;
    case (parse_phase)
      mrc_pkg::PhFirst: begin
        if (c == "a" || c == "A") parse_phase = mrc_pkg::PhSecond;
        else begin
          parse_phase = mrc_pkg::PhGap;
          to_gap = 1'b1;
        end
      end
      mrc_pkg::PhSecond: begin
        if (c == "t" || c == "T") parse_phase = mrc_pkg::PhEcho;
        else fix_verdict(mrc_pkg::VUnknown);
      end
      mrc_pkg::PhEcho: begin
        if (c == mrc_pkg::ChNul) fix_verdict(mrc_pkg::VNone);
        else if (crlf) parse_phase = mrc_pkg::PhGap;
      end
      mrc_pkg::PhGap: to_gap = 1'b1;
      mrc_pkg::PhMatch: begin
        if (c == mrc_pkg::ChNul) fix_verdict(mrc_pkg::VUnknown);
        else match_char(c);
      end
      default: ;
    endcase
    if (to_gap) begin
      if (c == mrc_pkg::ChNul) fix_verdict(mrc_pkg::VNone);
      else if (!crlf) begin
        parse_phase = mrc_pkg::PhMatch;
        match_char(c);
      end
    end
  endfunction

  function automatic bit classify_byte(input logic [7:0] c, input bit is_last,
                                       output mrc_pkg::verdict_e v);
    absorb_char(c);
    v = mrc_pkg::VNone;
    if (!is_last) return 1'b0;
    if (parse_phase == mrc_pkg::PhDone) v = fixed_verdict;
    else if (parse_phase == mrc_pkg::PhMatch || parse_phase == mrc_pkg::PhSecond)
      v = mrc_pkg::VUnknown;
    clear_parser();
    return 1'b1;
  endfunction

  task automatic send_reply(input logic [7:0] body [$], input bit use_typed,
                            input mrc_pkg::verdict_e typed_v);
    mrc_pkg::verdict_e v;
    int gap;
    bit is_last;
    foreach (body[i]) begin
      gap = pick_gap();
      is_last = (i == body.size() - 1);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      @(negedge clk_i);
      in_valid_i <= 1'b1;
      ch_i <= body[i];
      last_i <= is_last;
      do @(posedge clk_i); while (!in_ready_o);
      bytes_sent++;
      if (classify_byte(body[i], is_last, v)) verdicts_due.push_back(use_typed ? typed_v : v);
    end
    replies_sent++;
  endtask

  task automatic drain_verdicts();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic make_random_reply(ref logic [7:0] body [$]);
    int n;
    int k;
    int cut;
    string w;
    body.delete();
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        body.push_back(mixcase("A"));
        body.push_back(mixcase("T"));
        n = $urandom_range(0, 4);
        repeat (n) body.push_back(8'($urandom_range(32, 126)));
        case ($urandom_range(0, 5))
          0: body.push_back(mrc_pkg::ChNul);
          1: ;
          2, 3: body.push_back(mrc_pkg::ChCr);
          default: body.push_back(mrc_pkg::ChLf);
        endcase
      end
      n = $urandom_range(0, 3);
      repeat (n) body.push_back(($urandom_range(0, 1) == 1) ? mrc_pkg::ChCr : mrc_pkg::ChLf);
      if ($urandom_range(0, 19) != 0) begin
        k = $urandom_range(0, 8);
        w = kw_str[k];
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w.len()) : w.len();
        for (int i = 0; i < cut; i++) body.push_back(mixcase(w[i]));
        if ($urandom_range(0, 9) == 0)
          body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        n = $urandom_range(0, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: body.push_back(mrc_pkg::ChCr);
            1: body.push_back(mrc_pkg::ChLf);
            2: body.push_back(mrc_pkg::ChNul);
            default: body.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      if (body.size() == 0) body.push_back(mrc_pkg::ChCr);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict %0d arrived with none expected", $time, verdict_o);
        errors++;
      end else begin
        got_expect = verdicts_due.pop_front();
        verdicts_checked++;
        seen_verdict[got_expect]++;
        if (verdict_o !== got_expect) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d", $time,
                   got_expect, verdict_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] body [$];
    int start_bytes;
    int kinds;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      body.delete();
      for (int i = 0; i < directed_rows[r].txt.len(); i++) body.push_back(directed_rows[r].txt[i]);
      if (directed_rows[r].nul_tail) begin
        body.push_back(mrc_pkg::ChNul);
        body.push_back("x");
      end
      idle_on = (r >= 10);
      send_reply(body, directed_rows[r].typed, directed_rows[r].want);
    end

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RandomBytes) begin
      if (replies_sent % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (replies_sent % 100 == 50) drain_verdicts();
      make_random_reply(body);
      send_reply(body, 1'b0, mrc_pkg::VNone);
    end

    drain_verdicts();
    repeat (8) @(posedge clk_i);

    kinds = 0;
    foreach (seen_verdict[v]) if (seen_verdict[v] != 0) kinds++;
    $display("Sent %0d replies in %0d bytes; checked %0d verdicts.", replies_sent, bytes_sent,
             verdicts_checked);
    $display("Distinct verdict codes covered: %0d of 10.", kinds);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
